// ----- hdl/sfdn_pkg.sv -----
// Package for the stereo feedback-delay-network reverb core.
// Holds widths, register indexes, sine table function and shared types.
// No dependencies.
package sfdn_pkg;

   localparam int LineDepth = 8192;
   localparam int PtrW = 13;
   localparam int SineDepth = 1024;
   localparam int SineW = 10;
   localparam int Lines = 8;
   localparam int LineW = 3;
   localparam int SampleW = 24;
   localparam int CsrAddrW = 3;
   localparam int CsrDataW = 32;

   localparam logic [CsrAddrW-1:0] REG_FEEDBACK = 3'd0;
   localparam logic [CsrAddrW-1:0] REG_DAMPING = 3'd1;
   localparam logic [CsrAddrW-1:0] REG_MOTION = 3'd2;
   localparam logic [CsrAddrW-1:0] REG_LFO_INC = 3'd3;
   localparam logic [CsrAddrW-1:0] REG_SCALE = 3'd4;

   localparam logic signed [SampleW-1:0] FullPos = 24'sh7FFFFF;
   localparam logic signed [SampleW-1:0] FullNeg = -24'sh800000;

   typedef logic signed [SampleW-1:0] sample_type;

   // Configuration registers handed to the datapath.
   typedef struct packed {
      logic [15:0] feedback_gain;
      logic [15:0] damping_coef;
      logic [15:0] motion_depth;
      logic [31:0] lfo_increment;
      logic [15:0] line_scale;
   } csr_type;

   // Base distance for a line (0..3 left, 4..7 right reversed plus 37).
   function automatic logic [12:0] base_dist(input logic [LineW-1:0] line);
      logic [12:0] r;
      case (line)
         3'd0: r = 13'd2113;
         3'd1: r = 13'd2477;
         3'd2: r = 13'd2897;
         3'd3: r = 13'd3253;
         3'd4: r = 13'd3290;
         3'd5: r = 13'd2934;
         3'd6: r = 13'd2514;
         3'd7: r = 13'd2150;
         default: r = 13'd2113;
      endcase
      return r;
   endfunction

   // Sine table entry, Q1.15; constant table evaluated as logic.
   function automatic logic signed [16:0] sine_entry(input logic [SineW-1:0] k);
      logic [17:0] u;
      logic [1:0] quad;
      longint q, q2, s;
      u = 18'(k) << (18 - SineW);
      quad = u[17:16];
      q = longint'(u[15:0]);
      if (quad[0]) q = 65536 - q;
      q2 = (q * q) >>> 16;
      s = (q * (102944 - ((q2 * (42334 - ((5223 * q2) >>> 16))) >>> 16))) >>> 16;
      s = s >>> 1;
      if (s > 32767) s = 32767;
      if (s < 0) s = 0;
      if (quad[1]) s = -s;
      return 17'(s);
   endfunction

endpackage

// ----- hdl/sfdn_stream_if.sv -----
// Valid/ready stream interface carrying one stereo sample word.
// No dependencies.
interface sfdn_stream_if;
   logic valid;
   logic ready;
   logic signed [23:0] left;
   logic signed [23:0] right;
   modport source (output valid, left, right, input ready);
   modport sink (input valid, left, right, output ready);
endinterface

// ----- hdl/stereo_fdn_reverb_core.sv -----
// Top level of the stereo feedback-delay-network reverb core.
// Depends on sfdn_pkg, sfdn_stream_if and sfdn_datapath.
// Each word runs the LFO motion step, then reads, interpolates and damps the eight
// lines in turn through the single read port of the line memory, then soft-clips
// each line with the 53-step bit-serial divider and writes it back, then mixes and
// hands off the result. A new word is taken only once the core is idle and the
// previous result has left the output register. After reset a clearing pass zeroes
// the line memory; no word is accepted during it. One result at a time.
module stereo_fdn_reverb_core (
   input  logic clock,
   input  logic reset,
   sfdn_stream_if.sink req,
   sfdn_stream_if.source rsp,
   input  logic csr_we,
   input  logic [sfdn_pkg::CsrAddrW-1:0] csr_index,
   input  logic [sfdn_pkg::CsrDataW-1:0] csr_data
);
   import sfdn_pkg::*;

   csr_type csr_ff;
   logic busy, finish, full_ff;
   sample_type ol, orr;
   sample_type ol_ff, or_ff;

   // Register file.
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.feedback_gain <= 16'd45875;
         csr_ff.damping_coef <= 16'd32768;
         csr_ff.motion_depth <= 16'd0;
         csr_ff.lfo_increment <= 32'd2773;
         csr_ff.line_scale <= 16'd17833;
      end else if (csr_we) begin
         case (csr_index)
            REG_FEEDBACK: csr_ff.feedback_gain <= csr_data[15:0];
            REG_DAMPING: csr_ff.damping_coef <= csr_data[15:0];
            REG_MOTION: csr_ff.motion_depth <= csr_data[15:0];
            REG_LFO_INC: csr_ff.lfo_increment <= csr_data;
            REG_SCALE: csr_ff.line_scale <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   assign req.ready = !busy && !full_ff;

   sfdn_datapath u_dp (.clock, .reset, .csr(csr_ff), .start(req.valid && req.ready),
                       .in_l(req.left), .in_r(req.right), .busy, .finish,
                       .out_l(ol), .out_r(orr));

   // Output register holds a word until taken.
   always_ff @(posedge clock) begin
      if (reset) full_ff <= 1'b0;
      else if (finish) full_ff <= 1'b1;
      else if (rsp.ready) full_ff <= 1'b0;
      if (finish) begin
         ol_ff <= ol; or_ff <= orr;
      end
   end

   assign rsp.valid = full_ff;
   assign rsp.left = ol_ff;
   assign rsp.right = or_ff;

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      finish |-> !full_ff) else $error("overrun");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      full_ff |-> !req.ready) else $error("accept while full");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> busy) else $error("start lost");
endmodule

// ----- hdl/sfdn_softclip.sv -----
// Soft clipper: x*(27+x^2)/(27+9x^2) with a bit-serial restoring divider.
// Depends on sfdn_pkg.
module sfdn_softclip (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic signed [26:0] x_in,
   output logic done,
   output sfdn_pkg::sample_type y_out
);
   import sfdn_pkg::*;

   logic [25:0] m_ff, m_in;
   logic neg_ff, neg_in;
   logic [1:0] ph_ff, ph_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [49:0] x2p_ff, x2p_in;
   logic [52:0] num_ff, num_in;
   logic [30:0] den_ff, den_in;
   logic [31:0] rem_ff, rem_in;
   logic [23:0] quo_ff, quo_in;
   logic sat_ff, sat_in;
   logic done_ff, done_in;
   logic [26:0] x2;
   logic [31:0] trial;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_SQ = 2'd1;
   localparam logic [1:0] PH_NUM = 2'd2;
   localparam logic [1:0] PH_DIV = 2'd3;

   assign x2 = x2p_ff[49:23];
   assign trial = {rem_ff[30:0], num_ff[52]};

   // Square, numerator product, then one quotient bit per cycle.
   always_comb begin
      m_in = m_ff; neg_in = neg_ff; ph_in = ph_ff; cnt_in = cnt_ff;
      x2p_in = x2p_ff; num_in = num_ff; den_in = den_ff; rem_in = rem_ff;
      quo_in = quo_ff; sat_in = sat_ff; done_in = 1'b0;
      case (ph_ff)
         PH_IDLE: begin
            if (start) begin
               neg_in = x_in[26];
               m_in = x_in[26] ? 26'(-x_in) : 26'(x_in);
               ph_in = PH_SQ;
            end
         end
         PH_SQ: begin
            sat_in = (m_ff >= 26'(3 << 23));
            x2p_in = 50'(m_ff[24:0]) * 50'(m_ff[24:0]);
            ph_in = PH_NUM;
         end
         PH_NUM: begin
            num_in = 53'(m_ff[24:0]) * 53'({27'd27, 23'd0} + 50'(x2));
            den_in = 31'({5'd27, 23'd0}) + 31'(x2) * 31'd9;
            rem_in = '0; quo_in = '0; cnt_in = 6'd53;
            ph_in = PH_DIV;
         end
         PH_DIV: begin
            num_in = {num_ff[51:0], 1'b0};
            if (trial >= 32'(den_ff)) begin
               rem_in = trial - 32'(den_ff);
               quo_in = {quo_ff[22:0], 1'b1} | {24{quo_ff[23]}};
            end else begin
               rem_in = trial;
               quo_in = {quo_ff[22:0], 1'b0} | {24{quo_ff[23]}};
            end
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               ph_in = PH_IDLE;
               done_in = 1'b1;
            end
         end
         default: ph_in = PH_IDLE;
      endcase
   end

   // Quotient sticks at all ones once it would exceed 24 bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= PH_IDLE;
         done_ff <= 1'b0;
      end else begin
         ph_ff <= ph_in;
         done_ff <= done_in;
      end
      m_ff <= m_in; neg_ff <= neg_in; cnt_ff <= cnt_in; x2p_ff <= x2p_in;
      num_ff <= num_in; den_ff <= den_in; rem_ff <= rem_in; quo_ff <= quo_in;
      sat_ff <= sat_in;
   end

   logic [23:0] mag;
   assign mag = (sat_ff || quo_ff[23]) ? 24'h7FFFFF : quo_ff;
   assign done = done_ff;
   assign y_out = neg_ff ? sample_type'(-$signed({1'b0, mag})) : sample_type'(mag);
endmodule

// ----- hdl/sfdn_datapath.sv -----
// Sequencer, line memory, damping memory and mixer for the reverb core.
// Depends on sfdn_pkg and sfdn_softclip.
module sfdn_datapath (
   input  logic clock,
   input  logic reset,
   input  sfdn_pkg::csr_type csr,
   input  logic start,
   input  sfdn_pkg::sample_type in_l,
   input  sfdn_pkg::sample_type in_r,
   output logic busy,
   output logic finish,
   output sfdn_pkg::sample_type out_l,
   output sfdn_pkg::sample_type out_r
);
   import sfdn_pkg::*;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_CLEAR = 4'd1;
   localparam logic [3:0] ST_MOT = 4'd2;
   localparam logic [3:0] ST_ADDR = 4'd3;
   localparam logic [3:0] ST_RD1 = 4'd4;
   localparam logic [3:0] ST_RD2 = 4'd5;
   localparam logic [3:0] ST_INTERP = 4'd6;
   localparam logic [3:0] ST_DAMP = 4'd7;
   localparam logic [3:0] ST_FB = 4'd8;
   localparam logic [3:0] ST_CLIP = 4'd9;
   localparam logic [3:0] ST_WAIT = 4'd10;
   localparam logic [3:0] ST_OUT = 4'd11;
   localparam logic [3:0] ST_MIX = 4'd12;

   localparam int QuarterDepth = SineDepth / 4;

   logic signed [SampleW-1:0] line_mem [LineDepth*Lines];
   logic signed [SampleW-1:0] damp_mem [Lines];
   logic [3:0] st_ff, st_in;
   logic [15:0] clr_ff, clr_in;
   logic [PtrW-1:0] wp_ff, wp_in;
   logic [31:0] phase_ff, phase_in;
   logic [LineW-1:0] ln_ff, ln_in;
   logic signed [34:0] mot_ff, mot_in;
   logic signed [36:0] dist_ff, dist_in;
   logic [PtrW-1:0] i0_ff, i0_in;
   logic [15:0] frac_ff, frac_in;
   logic signed [SampleW-1:0] s0_ff, s0_in, rd_q;
   logic signed [SampleW-1:0] tap_ff [Lines];
   logic signed [SampleW-1:0] tap_in;
   logic signed [SampleW-1:0] xl_ff, xr_ff;
   logic signed [SampleW-1:0] ol_ff, or_ff, ol_in, or_in;
   logic signed [24:0] ipol_ff, ipol_in;
   logic signed [26:0] clip_x;
   logic clip_go, clip_done;
   sample_type clip_y;
   logic [15:0] rd_addr;
   logic mem_we;
   logic [15:0] wr_addr;
   logic signed [SampleW-1:0] wr_data;

   sfdn_softclip u_clip (.clock, .reset, .start(clip_go), .x_in(clip_x),
                         .done(clip_done), .y_out(clip_y));

   // Per-line distance in Q16.16.
   logic signed [36:0] prod_dist;
   assign prod_dist = 37'sd0 + 37'($unsigned(30'(base_dist(ln_ff)) * 30'(csr.line_scale)))
                     * 37'sd4;

   logic signed [36:0] dclamp;
   logic signed [37:0] pos;
   always_comb begin
      dclamp = dist_ff;
      if (dist_ff < 37'sd65536) dclamp = 37'sd65536;
      if (dist_ff > 37'(signed'((LineDepth - 2) * 65536))) dclamp = 37'((LineDepth - 2) * 65536);
      pos = 38'({wp_ff, 16'd0}) - 38'(dclamp);
      if (pos < 0) pos = pos + 38'(LineDepth * 65536);
   end

   // Matrix row for the line being written, sign pattern per row.
   logic signed [27:0] row;
   logic [LineW-1:0] b;
   always_comb begin
      b = {ln_ff[2], 2'b00};
      case (ln_ff[1:0])
         2'd0: row = 28'(tap_ff[b]) + 28'(tap_ff[b+1]) - 28'(tap_ff[b+2]) - 28'(tap_ff[b+3]);
         2'd1: row = 28'(tap_ff[b]) - 28'(tap_ff[b+1]) + 28'(tap_ff[b+2]) - 28'(tap_ff[b+3]);
         2'd2: row = 28'(tap_ff[b]) - 28'(tap_ff[b+1]) - 28'(tap_ff[b+2]) + 28'(tap_ff[b+3]);
         default: row = 28'(tap_ff[b]) + 28'(tap_ff[b+1]) + 28'(tap_ff[b+2])
                        + 28'(tap_ff[b+3]);
      endcase
   end
   logic signed [44:0] fbp;
   assign fbp = 45'(row) * $signed({1'b0, csr.feedback_gain});

   // Damping step.
   logic signed [SampleW-1:0] dst;
   logic signed [42:0] dprod;
   logic signed [25:0] dsum;
   assign dst = damp_mem[ln_ff];
   assign dprod = 43'(ipol_ff - 25'(dst)) * $signed({1'b0, csr.damping_coef});
   always_comb begin
      dsum = 26'(dst) + 26'(dprod >>> 16);
      if (dsum > 26'(FullPos)) tap_in = FullPos;
      else if (dsum < 26'(FullNeg)) tap_in = FullNeg;
      else tap_in = SampleW'(dsum);
   end

   // Output mix terms.
   logic signed [27:0] mixl, mixr;
   logic signed [43:0] pl, pr;
   assign mixl = 28'(tap_ff[0]) - 28'(tap_ff[1]) + 28'(tap_ff[2]) - 28'(tap_ff[3])
               + 28'(tap_ff[5] >>> 2);
   assign mixr = 28'(tap_ff[4]) - 28'(tap_ff[5]) + 28'(tap_ff[6]) - 28'(tap_ff[7])
               + 28'(tap_ff[2] >>> 2);
   assign pl = (44'(mixl) * 44'sd18350) >>> 16;
   assign pr = (44'(mixr) * 44'sd18350) >>> 16;

   // Quarter-wave sine table built from the polynomial; the other quadrants fold onto it.
   logic [15:0] quarter_rom [QuarterDepth+1];
   logic [SineW-1:0] sidx;
   logic [SineW-2:0] qidx;
   logic [15:0] smag;
   logic signed [16:0] sine;
   for (genvar g = 0; g <= QuarterDepth; g++) begin : g_quarter
      assign quarter_rom[g] = 16'(sine_entry(SineW'(g)));
   end
   assign sidx = phase_ff[31 -: SineW];
   assign qidx = sidx[SineW-2] ? (SineW-1)'(QuarterDepth) - {1'b0, sidx[SineW-3:0]}
                               : {1'b0, sidx[SineW-3:0]};
   assign smag = quarter_rom[qidx];
   assign sine = sidx[SineW-1] ? -$signed({1'b0, smag}) : $signed({1'b0, smag});

   always_comb begin
      st_in = st_ff; clr_in = clr_ff; wp_in = wp_ff; phase_in = phase_ff;
      ln_in = ln_ff; mot_in = mot_ff; dist_in = dist_ff; i0_in = i0_ff;
      frac_in = frac_ff; s0_in = s0_ff; ipol_in = ipol_ff; ol_in = ol_ff;
      or_in = or_ff;
      rd_addr = {ln_ff, i0_ff}; mem_we = 1'b0; wr_addr = {ln_ff, wp_ff};
      wr_data = clip_y; clip_go = 1'b0; finish = 1'b0;
      clip_x = (ln_ff[2] ? 27'(xr_ff) : 27'(xl_ff)) + 27'(fbp >>> 17);
      case (st_ff)
         ST_CLEAR: begin
            mem_we = 1'b1; wr_addr = clr_ff; wr_data = '0;
            clr_in = clr_ff + 16'd1;
            if (clr_ff == 16'hFFFF) st_in = ST_IDLE;
         end
         ST_IDLE: if (start) begin
            st_in = ST_MOT; ln_in = '0;
         end
         ST_MOT: begin
            mot_in = 35'((43'(sine) * $signed({1'b0, csr.motion_depth}) * 43'sd11) >>> 15);
            st_in = ST_ADDR;
         end
         ST_ADDR: begin
            dist_in = ln_ff[2] ? prod_dist - 37'(mot_ff) : prod_dist + 37'(mot_ff);
            st_in = ST_RD1;
         end
         ST_RD1: begin
            i0_in = pos[16+PtrW-1:16]; frac_in = pos[15:0];
            rd_addr = {ln_ff, pos[16+PtrW-1:16]};
            st_in = ST_RD2;
         end
         ST_RD2: begin
            rd_addr = {ln_ff, i0_ff + 13'd1};
            s0_in = rd_q;
            st_in = ST_INTERP;
         end
         // The second sample is read again so it is still on the port in the next step.
         ST_INTERP: begin
            rd_addr = {ln_ff, i0_ff + 13'd1};
            st_in = ST_DAMP;
         end
         ST_DAMP: begin
            ipol_in = 25'(s0_ff) + 25'((42'(25'(rd_q) - 25'(s0_ff)) * $signed({1'b0, frac_ff}))
                      >>> 16);
            st_in = ST_FB;
         end
         ST_FB: begin
            ln_in = ln_ff + 3'd1;
            st_in = (ln_ff == 3'd7) ? ST_CLIP : ST_ADDR;
         end
         ST_CLIP: begin
            clip_go = 1'b1; st_in = ST_WAIT;
         end
         ST_WAIT: if (clip_done) begin
            mem_we = 1'b1;
            ln_in = ln_ff + 3'd1;
            st_in = (ln_ff == 3'd7) ? ST_MIX : ST_CLIP;
         end
         ST_MIX: begin
            ol_in = (pl > 44'(FullPos)) ? FullPos : (pl < 44'(FullNeg)) ? FullNeg
                    : SampleW'(pl);
            or_in = (pr > 44'(FullPos)) ? FullPos : (pr < 44'(FullNeg)) ? FullNeg
                    : SampleW'(pr);
            st_in = ST_OUT;
         end
         ST_OUT: begin
            finish = 1'b1; wp_in = wp_ff + 13'd1;
            phase_in = phase_ff + csr.lfo_increment;
            st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   // Line memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) line_mem[wr_addr] <= wr_data;
      rd_q <= line_mem[rd_addr];
   end

   // Damping state and taps; the damp step runs in ST_FB.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < Lines; k++) damp_mem[k] <= '0;
      end else if (st_ff == ST_FB) begin
         damp_mem[ln_ff] <= tap_in;
      end
      if (st_ff == ST_FB) tap_ff[ln_ff] <= tap_in;
      if (st_ff == ST_IDLE && start) begin
         xl_ff <= in_l; xr_ff <= in_r;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_CLEAR; clr_ff <= '0; wp_ff <= '0; phase_ff <= '0; ln_ff <= '0;
      end else begin
         st_ff <= st_in; clr_ff <= clr_in; wp_ff <= wp_in; phase_ff <= phase_in;
         ln_ff <= ln_in;
      end
      mot_ff <= mot_in; dist_ff <= dist_in; i0_ff <= i0_in; frac_ff <= frac_in;
      s0_ff <= s0_in; ipol_ff <= ipol_in; ol_ff <= ol_in; or_ff <= or_in;
   end

   assign busy = (st_ff != ST_IDLE);
   assign out_l = ol_ff;
   assign out_r = or_ff;

   a_wp_step: assert property (@(posedge clock) disable iff (reset)
      finish |=> wp_ff == $past(wp_ff) + 13'd1) else $error("pointer step");
   a_clip_wait: assert property (@(posedge clock) disable iff (reset)
      clip_go |=> st_ff == ST_WAIT) else $error("clip handshake");
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (st_ff == ST_WAIT || st_ff == ST_CLEAR)) else $error("stray write");
endmodule

// ----- sim/tb_stereo_fdn_reverb_core.sv -----
// Self-checking testbench for stereo_fdn_reverb_core: directed and random
// stereo words, several register settings, and a bit-exact fixed-point predictor.
// Depends on sfdn_pkg, sfdn_stream_if and the core itself.
`timescale 1ns / 100ps

module tb_stereo_fdn_reverb_core;
   import sfdn_pkg::*;

   localparam int LIMIT_CYCLES = 4000000;
   localparam int DRAIN_CYCLES = 600;

   typedef struct {
      sample_type l;
      sample_type r;
   } word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CsrAddrW-1:0] csr_index = '0;
   logic [CsrDataW-1:0] csr_data = '0;

   sfdn_stream_if req_ch ();
   sfdn_stream_if rsp_ch ();

   stereo_fdn_reverb_core DUT (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // Predictor state: delay rings, damping filters, pointer, LFO and registers.
   logic signed [23:0] ring [Lines][LineDepth];
   longint damp_st [Lines];
   longint sine_lut [SineDepth];
   int wptr;
   logic [31:0] lfo_phase;
   longint cfg_fb, cfg_damp, cfg_depth, cfg_scale;
   logic [31:0] cfg_inc;

   word_type pending [$];
   word_type reverb_q [$];
   int errors = 0;
   int results_seen = 0;
   int cycles = 0;

   function automatic longint sat24(input longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
   endfunction

   // Quarter-wave polynomial sine, Q1.15.
   function automatic longint sine_value(input int k);
      longint u, q, q2, s;
      int quad;
      u = (longint'(k) << 18) / SineDepth;
      quad = int'((u >> 16) & 3);
      q = u & 65535;
      if (quad % 2 == 1) q = 65536 - q;
      q2 = (q * q) >>> 16;
      s = (q * (102944 - ((q2 * (42334 - ((5223 * q2) >>> 16))) >>> 16))) >>> 16;
      s = s >>> 1;
      if (s > 32767) s = 32767;
      if (s < 0) s = 0;
      return (quad >= 2) ? -s : s;
   endfunction

   function automatic longint soft_clip(input longint x);
      longint m, y, x2, num, den;
      m = (x < 0) ? -x : x;
      if (m >= (longint'(3) << 23)) begin
         y = 8388607;
      end else begin
         x2 = (m * m) >>> 23;
         num = m * ((longint'(27) << 23) + x2);
         den = (longint'(27) << 23) + 9 * x2;
         y = num / den;
         if (y > 8388607) y = 8388607;
      end
      return (x < 0) ? -y : y;
   endfunction

   // Interpolated ring read at a Q16.16 distance behind the write pointer.
   function automatic longint read_line(input int ln, input longint span);
      longint pos, frac, s0, s1;
      int i0, i1;
      if (span < 65536) span = 65536;
      if (span > longint'(LineDepth - 2) << 16) span = longint'(LineDepth - 2) << 16;
      pos = (longint'(wptr) << 16) - span;
      if (pos < 0) pos += longint'(LineDepth) << 16;
      i0 = int'(pos >>> 16);
      if (i0 >= LineDepth) i0 = 0;
      i1 = (i0 + 1 >= LineDepth) ? 0 : i0 + 1;
      frac = pos & 65535;
      s0 = ring[ln][i0];
      s1 = ring[ln][i1];
      return s0 + (((s1 - s0) * frac) >>> 16);
   endfunction

   function automatic longint damp_line(input int ln, input longint x);
      damp_st[ln] = sat24(damp_st[ln] + ((cfg_damp * (x - damp_st[ln])) >>> 16));
      return damp_st[ln];
   endfunction

   // One sample period of the reverb; queues the expected output word.
   function automatic void reverb_step(input sample_type in_l, input sample_type in_r);
      longint base [4];
      longint tap [Lines];
      longint mix [Lines];
      longint motion, ol, orr;
      word_type w;
      int sidx;
      base = '{2113, 2477, 2897, 3253};
      sidx = int'((longint'(lfo_phase) * SineDepth) >> 32);
      if (sidx >= SineDepth) sidx = 0;
      motion = (sine_lut[sidx] * cfg_depth * 11) >>> 15;
      for (int i = 0; i < 4; i++) begin
         tap[i] = damp_line(i, read_line(i, base[i] * cfg_scale * 4 + motion));
         tap[4 + i] = damp_line(4 + i,
            read_line(4 + i, (base[3 - i] + 37) * cfg_scale * 4 - motion));
      end
      // Sign matrix per side.
      for (int s = 0; s < 8; s += 4) begin
         mix[s]     = tap[s] + tap[s + 1] - tap[s + 2] - tap[s + 3];
         mix[s + 1] = tap[s] - tap[s + 1] + tap[s + 2] - tap[s + 3];
         mix[s + 2] = tap[s] - tap[s + 1] - tap[s + 2] + tap[s + 3];
         mix[s + 3] = tap[s] + tap[s + 1] + tap[s + 2] + tap[s + 3];
      end
      for (int i = 0; i < 4; i++) begin
         ring[i][wptr] = 24'(soft_clip(longint'(in_l) + ((mix[i] * cfg_fb) >>> 17)));
         ring[4 + i][wptr] =
            24'(soft_clip(longint'(in_r) + ((mix[4 + i] * cfg_fb) >>> 17)));
      end
      wptr = (wptr + 1 >= LineDepth) ? 0 : wptr + 1;
      lfo_phase = lfo_phase + cfg_inc;
      ol = ((tap[0] - tap[1] + tap[2] - tap[3] + (tap[5] >>> 2)) * 18350) >>> 16;
      orr = ((tap[4] - tap[5] + tap[6] - tap[7] + (tap[2] >>> 2)) * 18350) >>> 16;
      w.l = sample_type'(sat24(ol));
      w.r = sample_type'(sat24(orr));
      reverb_q.push_back(w);
   endfunction

   // Sender: bursts of words separated by random gaps.
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      word_type w;
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.left <= '0;
         req_ch.right <= '0;
         burst_left <= 0;
         gap_left <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) reverb_step(req_ch.left, req_ch.right);
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0) begin
               req_ch.valid <= 1'b0;
               gap_left <= gap_left - 1;
            end else if (pending.size() > 0) begin
               w = pending.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.left <= w.l;
               req_ch.right <= w.r;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 12);
                  case ($urandom_range(0, 3))
                     0: gap_left <= 0;
                     1: gap_left <= $urandom_range(1, 8);
                     2: gap_left <= $urandom_range(1, 80);
                     default: gap_left <= $urandom_range(100, 700);
                  endcase
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: changing stall pattern, plus one long hold-off to back up the input.
   int hold_left = 0;
   bit hold_done = 1'b0;
   int mode = 0;
   int mode_left = 0;
   always @(posedge clock) begin
      word_type w;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_seen <= results_seen + 1;
            if (reverb_q.size() == 0) begin
               errors <= errors + 1;
               if (errors < 10)
                  $display("unexpected word: left %0d right %0d",
                     rsp_ch.left, rsp_ch.right);
            end else begin
               w = reverb_q.pop_front();
               if (w.l !== rsp_ch.left || w.r !== rsp_ch.right) begin
                  errors <= errors + 1;
                  if (errors < 10)
                     $display("word %0d mismatch: left exp %0d got %0d, right exp %0d got %0d",
                        results_seen, w.l, rsp_ch.left, w.r, rsp_ch.right);
               end
            end
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
         end else if (!hold_done && results_seen == 300) begin
            rsp_ch.ready <= 1'b0;
            hold_left <= 4000;
            hold_done <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               mode <= $urandom_range(0, 2);
               mode_left <= $urandom_range(20, 2000);
            end else begin
               mode_left <= mode_left - 1;
            end
            case (mode)
               0: rsp_ch.ready <= 1'b1;
               1: rsp_ch.ready <= 1'($urandom_range(0, 1));
               default: rsp_ch.ready <= ($urandom_range(0, 15) == 0);
            endcase
         end
      end
   end

   // Run limit.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT_CYCLES) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic add_word(input int l, input int r);
      word_type w;
      w.l = sample_type'(l);
      w.r = sample_type'(r);
      pending.push_back(w);
   endtask

   // Random content: mostly full-range noise, with quiet, small and full-scale words mixed in.
   task automatic add_random(input int n);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 9))
            0, 1: add_word($urandom_range(0, 8191) - 4096, $urandom_range(0, 8191) - 4096);
            2: add_word($urandom_range(0, 1) ? 8388607 : -8388608,
                  $urandom_range(0, 1) ? 8388607 : -8388608);
            3: add_word(0, 0);
            default: add_word(int'($urandom()), int'($urandom()));
         endcase
      end
   endtask

   task automatic write_reg(input logic [CsrAddrW-1:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_FEEDBACK: cfg_fb = longint'(val[15:0]);
         REG_DAMPING: cfg_damp = longint'(val[15:0]);
         REG_MOTION: cfg_depth = longint'(val[15:0]);
         REG_LFO_INC: cfg_inc = val;
         REG_SCALE: cfg_scale = longint'(val[15:0]);
         default: ;
      endcase
   endtask

   task automatic set_all(input logic [31:0] fb, input logic [31:0] dc,
      input logic [31:0] md, input logic [31:0] inc, input logic [31:0] sc);
      write_reg(REG_FEEDBACK, fb);
      write_reg(REG_DAMPING, dc);
      write_reg(REG_MOTION, md);
      write_reg(REG_LFO_INC, inc);
      write_reg(REG_SCALE, sc);
   endtask

   task automatic wait_drained();
      while (pending.size() != 0 || reverb_q.size() != 0 || req_ch.valid)
         @(posedge clock);
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.left = '0;
      req_ch.right = '0;
      rsp_ch.ready = 1'b0;
      for (int ln = 0; ln < Lines; ln++) begin
         damp_st[ln] = 0;
         for (int k = 0; k < LineDepth; k++) ring[ln][k] = '0;
      end
      for (int k = 0; k < SineDepth; k++) sine_lut[k] = sine_value(k);
      wptr = 0;
      lfo_phase = '0;
      cfg_fb = 45875;
      cfg_damp = 32768;
      cfg_depth = 0;
      cfg_inc = 32'd2773;
      cfg_scale = 17833;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed words at reset settings: extremes, impulses and full-scale runs.
      add_word(8388607, 8388607);
      add_word(-8388608, -8388608);
      add_word(0, 0);
      add_word(8388607, -8388608);
      add_word(-8388608, 8388607);
      add_word(1, -1);
      add_word(-1, 1);
      add_word(4194304, -4194304);
      for (int i = 0; i < 6; i++) add_word(8388607, -8388608);
      for (int i = 0; i < 4; i++) add_word(0, 0);
      wait_drained();

      // Zero scale: each distance is the motion alone, at least one sample; feedback saturates.
      set_all(32'd65535, 32'd65535, 32'd65535, 32'($urandom()), 32'd0);
      for (int i = 0; i < 20; i++) add_word(8388607, -8388608);
      add_random(130);
      wait_drained();

      // Lines at a quarter of their base length, no feedback, frozen damping and LFO.
      set_all(32'd0, 32'd0, 32'd0, 32'd0, 32'd4096);
      add_random(100);
      wait_drained();

      // Quarter-length lines, full feedback and motion, slowest backwards LFO.
      set_all(32'd65535, 32'd65535, 32'd65535, 32'hFFFFFFFF, 32'd4096);
      add_random(600);
      wait_drained();

      // Longest scale clamps at the ring depth; writes to unused indexes are ignored.
      write_reg(3'd5, 32'($urandom()));
      write_reg(3'd7, 32'($urandom()));
      set_all(32'($urandom_range(0, 65535)), 32'($urandom_range(0, 65535)),
         32'($urandom_range(0, 65535)), 32'($urandom()), 32'd65535);
      add_random(150);
      wait_drained();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && reverb_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/sfdn_pkg.sv
hdl/sfdn_stream_if.sv
hdl/sfdn_softclip.sv
hdl/sfdn_datapath.sv
hdl/stereo_fdn_reverb_core.sv
sim/tb_stereo_fdn_reverb_core.sv
